// File: sv/polygon_vertex_offset_macros.svh
// ----------------------------------------------------------------------------
// polygon_vertex_offset assertion macros
// Shorthand for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef POLYGON_VERTEX_OFFSET_MACROS_SVH
`define POLYGON_VERTEX_OFFSET_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PVO_ASSERT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PVO_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pvo_pkg.sv
// ----------------------------------------------------------------------------
// pvo_pkg
// Shared constants, types and the arctangent table of the vertex offset block.
// ----------------------------------------------------------------------------
package pvo_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_CORDIC_STEPS = 24;

  // CORDIC datapath and angle widths
  localparam int CDW = 44;
  localparam int ZW  = 34;

  localparam int DIST_W = 31;
  localparam int CFG_IW = 1;
  localparam int DVD_W  = 61;
  localparam int DVS_W  = 32;
  localparam int MAG_W  = 32;

  localparam logic signed [ZW-1:0]  HALF_TURN    = 34'sd2147483648;
  localparam logic signed [ZW-1:0]  QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [CDW-1:0] GAIN_INV     = 44'sd652032874;
  localparam logic signed [31:0]    PROBE_Q24    = 32'sd16777;
  localparam logic [MAG_W-1:0]      MAG_CAP      = 32'hFFFF_FFFF;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  localparam logic [CFG_IW-1:0] REG_OFFSET_DISTANCE = 1'b0;
  localparam logic [CFG_IW-1:0] REG_GROW_OUTWARD    = 1'b1;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // atan(2^-i) in binary angle units, full turn = 2^32
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/pvo_if.sv
// ----------------------------------------------------------------------------
// pvo_if
// Valid/ready channels for vertex requests and offset results.
// ----------------------------------------------------------------------------
interface pvo_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;

  modport source (output valid, kind, vertex_x, vertex_y, input ready);
  modport sink   (input valid, kind, vertex_x, vertex_y, output ready);
endinterface

interface pvo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic               last_vertex;
  logic [1:0]         status;

  modport source (output valid, offset_x, offset_y, last_vertex, status, input ready);
  modport sink   (input valid, offset_x, offset_y, last_vertex, status, output ready);
endinterface

// File: sv/polygon_vertex_offset.sv
// ----------------------------------------------------------------------------
// polygon_vertex_offset
// Offsets every stored polygon vertex along its angle bisector.
// ----------------------------------------------------------------------------
// A load request (kind 0) stores one Q16.16 vertex; loads past MAX_VERTICES
// are dropped. A run request (kind 1) clears the count when it is accepted
// and emits one offset vertex per stored vertex in index order, last_vertex
// set on the final one; a run with nothing stored returns one result with
// status 2. The block takes no request while a run is in progress. Every
// angle, sine and cosine comes from one shared iterative CORDIC unit; each
// operation holds the sequencer through launch, the micro-rotations and
// capture, so the inside test dominates a run. The bit-serial divider
// works out 61 quotient bits per vertex between its launch and capture.
// Output back-pressure stalls a run further. The vertex store is a memory
// with one write port and a registered read port; entries read before being
// written carry no meaning. Configuration writes belong between runs; a
// write during a run reaches the vertices still to come.
// ----------------------------------------------------------------------------
`include "polygon_vertex_offset_macros.svh"

module polygon_vertex_offset #(
  parameter int MAX_VERTICES = pvo_pkg::DEF_MAX_VERTICES,
  parameter int CORDIC_STEPS = pvo_pkg::DEF_CORDIC_STEPS
) (
  input  logic                         clk,
  input  logic                         rst,
  pvo_in_if.sink                       in_ch,
  pvo_out_if.source                    out_ch,
  input  logic                         wr_en,
  input  logic [pvo_pkg::CFG_IW-1:0]   wr_index,
  input  logic [pvo_pkg::DIST_W-1:0]   wr_data
);
  import pvo_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int PW = 42;   // probe-relative coordinates, 24 fraction bits
  localparam int WW = 36;   // winding term before wrap
  localparam int TW = 41;   // winding sum
  localparam int RW = 37;   // offset coordinate before saturation

  localparam logic signed [WW-1:0] W_HALF = 36'sd2147483648;
  localparam logic signed [WW-1:0] W_FULL = 36'sd4294967296;
  localparam logic signed [RW-1:0] SAT_HI = 37'sd2147483647;
  localparam logic signed [RW-1:0] SAT_LO = -37'sd2147483648;

  // sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_EMPTY    = 5'd1;
  localparam logic [4:0] S_RD_P     = 5'd2;
  localparam logic [4:0] S_RD_PREV  = 5'd3;
  localparam logic [4:0] S_RD_NEXT  = 5'd4;
  localparam logic [4:0] S_CAP_NEXT = 5'd5;
  localparam logic [4:0] S_VEC1     = 5'd6;
  localparam logic [4:0] S_VEC2     = 5'd7;
  localparam logic [4:0] S_ROT1     = 5'd8;
  localparam logic [4:0] S_ROT2     = 5'd9;
  localparam logic [4:0] S_DIV      = 5'd10;
  localparam logic [4:0] S_PMUL1    = 5'd11;
  localparam logic [4:0] S_PMUL2    = 5'd12;
  localparam logic [4:0] S_PMUL3    = 5'd13;
  localparam logic [4:0] S_W_RDA    = 5'd14;
  localparam logic [4:0] S_W_RDB    = 5'd15;
  localparam logic [4:0] S_W_CAPB   = 5'd16;
  localparam logic [4:0] S_W_VA     = 5'd17;
  localparam logic [4:0] S_W_VB     = 5'd18;
  localparam logic [4:0] S_W_NEXT   = 5'd19;
  localparam logic [4:0] S_MMUL1    = 5'd20;
  localparam logic [4:0] S_MMUL2    = 5'd21;
  localparam logic [4:0] S_MMUL3    = 5'd22;
  localparam logic [4:0] S_EMIT     = 5'd23;

  // wrap an angle difference into (-pi, pi]
  function automatic logic signed [WW-1:0] wrap_turn(input logic signed [WW-1:0] d);
    logic signed [WW-1:0] r;
    r = d;
    if (r > W_HALF) r = r - W_FULL;
    if (r > W_HALF) r = r - W_FULL;
    if (r <= -W_HALF) r = r + W_FULL;
    if (r <= -W_HALF) r = r + W_FULL;
    return r;
  endfunction

  // saturate to signed 32 bits; MSB of the result is the overflow flag
  function automatic logic [32:0] sat32(input logic signed [RW-1:0] v);
    logic [32:0] r;
    if (v > SAT_HI)      r = {1'b1, 32'h7FFF_FFFF};
    else if (v < SAT_LO) r = {1'b1, 32'h8000_0000};
    else                 r = {1'b0, v[31:0]};
    return r;
  endfunction

  // configuration
  logic [DIST_W-1:0] offset_distance;
  logic              grow_outward;

  // control
  logic [4:0]    state;
  logic [CW-1:0] vertex_count;
  logic [AW-1:0] nlast, p, wi, prev_idx, next_idx, wj, rd_addr;
  logic          launched, in_acc, mem_we, emit_load;

  // vertex store
  logic [63:0] mem [MAX_VERTICES];
  logic [63:0] mem_q;

  // per-vertex working registers
  logic signed [31:0]    cx, cy, pvx, pvy, nvx, nvy, wax, way, wbx, wby;
  logic signed [ZW-1:0]  t1, t2, ang_a, bis, half;
  logic signed [ZW:0]    tsum, tdiff, tabs;
  logic signed [31:0]    cs_c, cs_s, hs;
  logic [MAG_W-1:0]      mag;
  logic                  mag_flag;
  logic signed [PW-1:0]  qx, qy, ax, ay, bx, by;
  logic signed [TW-1:0]  total;
  logic signed [35:0]    mx, my, prod_q;
  logic                  w_skip, probe_in, forward;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod;

  // output register
  logic               out_valid, out_last;
  logic signed [31:0] out_x, out_y;
  logic [1:0]         out_status;

  // emit path
  logic signed [RW-1:0] sum_x, sum_y;
  logic [32:0]          sat_x, sat_y;

  // units
  cordic_ctl_t          cu_ctl;
  unit_sts_t            cu_sts, dv_sts;
  logic signed [CDW-1:0] cu_xin, cu_yin, cu_x, cu_y;
  logic signed [ZW-1:0]  cu_zin, cu_z;
  logic                  dv_start;
  logic [DVD_W-1:0]      dv_q;

  pvo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cu_ctl),
    .x_in  (cu_xin),
    .y_in  (cu_yin),
    .z_in  (cu_zin),
    .sts   (cu_sts),
    .x_out (cu_x),
    .y_out (cu_y),
    .z_out (cu_z)
  );

  pvo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend ({offset_distance, 30'd0}),
    .divisor  (hs[DVS_W-1:0]),
    .sts      (dv_sts),
    .quotient (dv_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_distance <= 31'd65536;
      grow_outward    <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OFFSET_DISTANCE: offset_distance <= wr_data;
        REG_GROW_OUTWARD:    grow_outward    <= wr_data[0];
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign mem_we      = in_acc && (in_ch.kind == KIND_LOAD) &&
                       (vertex_count < CW'(MAX_VERTICES));

  // cyclic neighbors
  assign prev_idx = (p == '0) ? nlast : p - 1'b1;
  assign next_idx = (p == nlast) ? '0 : p + 1'b1;
  assign wj       = (wi == nlast) ? '0 : wi + 1'b1;

  always_comb begin
    unique case (state)
      S_RD_PREV: rd_addr = prev_idx;
      S_RD_NEXT: rd_addr = next_idx;
      S_W_RDA:   rd_addr = wi;
      S_W_RDB:   rd_addr = wj;
      default:   rd_addr = p;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[vertex_count[AW-1:0]] <= {in_ch.vertex_y, in_ch.vertex_x};
    mem_q <= mem[rd_addr];
  end

  // angle arithmetic
  assign tsum  = (ZW+1)'(t1) + (ZW+1)'(t2);
  assign tdiff = (ZW+1)'(t1) - (ZW+1)'(t2);
  assign tabs  = (tdiff < 0) ? -tdiff : tdiff;
  assign bis   = ZW'(tsum >>> 1);
  assign half  = ZW'(tabs >>> 1);

  // winding test vectors from probe point
  assign ax       = PW'($signed({wax, 8'h00})) - qx;
  assign ay       = PW'($signed({way, 8'h00})) - qy;
  assign bx       = PW'($signed({wbx, 8'h00})) - qx;
  assign by       = PW'($signed({wby, 8'h00})) - qy;
  assign w_skip   = (ax == 0 && ay == 0) || (bx == 0 && by == 0);
  assign probe_in = (total >= TW'(W_HALF)) || (total <= -TW'(W_HALF));

  // CORDIC request mux
  always_comb begin
    cu_ctl.start  = 1'b0;
    cu_ctl.rotate = 1'b0;
    cu_xin        = '0;
    cu_yin        = '0;
    cu_zin        = '0;
    unique case (state)
      S_VEC1: begin
        cu_ctl.start = !launched;
        cu_xin       = CDW'(pvx) - CDW'(cx);
        cu_yin       = CDW'(pvy) - CDW'(cy);
      end
      S_VEC2: begin
        cu_ctl.start = !launched;
        cu_xin       = CDW'(nvx) - CDW'(cx);
        cu_yin       = CDW'(nvy) - CDW'(cy);
      end
      S_ROT1: begin
        cu_ctl.start  = !launched;
        cu_ctl.rotate = 1'b1;
        cu_zin        = bis;
      end
      S_ROT2: begin
        cu_ctl.start  = !launched;
        cu_ctl.rotate = 1'b1;
        cu_zin        = half;
      end
      S_W_VA: begin
        cu_ctl.start = !launched && !w_skip;
        cu_xin       = CDW'(ax);
        cu_yin       = CDW'(ay);
      end
      S_W_VB: begin
        cu_ctl.start = !launched;
        cu_xin       = CDW'(bx);
        cu_yin       = CDW'(by);
      end
      default: begin
        cu_ctl.start = 1'b0;
      end
    endcase
  end

  assign dv_start = (state == S_DIV) && !launched && (hs > 0);

  // shared multiplier, registered product
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_PMUL1: begin mul_a = 34'(cs_c); mul_b = PROBE_Q24; end
      S_PMUL2: begin mul_a = 34'(cs_s); mul_b = PROBE_Q24; end
      S_MMUL1: begin mul_a = $signed({2'b00, mag}); mul_b = cs_c; end
      S_MMUL2: begin mul_a = $signed({2'b00, mag}); mul_b = cs_s; end
      default: begin mul_a = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign prod_q = $signed(prod[65:30]);

  // final move and saturation
  assign forward   = (probe_in != grow_outward);
  assign sum_x     = forward ? RW'(cx) + RW'(mx) : RW'(cx) - RW'(mx);
  assign sum_y     = forward ? RW'(cy) + RW'(my) : RW'(cy) - RW'(my);
  assign sat_x     = sat32(sum_x);
  assign sat_y     = sat32(sum_y);
  assign emit_load = ((state == S_EMIT) || (state == S_EMPTY)) &&
                     (!out_valid || out_ch.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      launched     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (emit_load)         out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.kind == KIND_LOAD) begin
              if (vertex_count < CW'(MAX_VERTICES)) vertex_count <= vertex_count + 1'b1;
            end else begin
              vertex_count <= '0;
              nlast        <= AW'(vertex_count - 1'b1);
              p            <= '0;
              state        <= (vertex_count == '0) ? S_EMPTY : S_RD_P;
            end
          end
        end
        S_RD_P: state <= S_RD_PREV;
        S_RD_PREV: begin
          cx    <= $signed(mem_q[31:0]);
          cy    <= $signed(mem_q[63:32]);
          state <= S_RD_NEXT;
        end
        S_RD_NEXT: begin
          pvx   <= $signed(mem_q[31:0]);
          pvy   <= $signed(mem_q[63:32]);
          state <= S_CAP_NEXT;
        end
        S_CAP_NEXT: begin
          nvx   <= $signed(mem_q[31:0]);
          nvy   <= $signed(mem_q[63:32]);
          state <= S_VEC1;
        end
        S_VEC1: begin
          if (!launched) launched <= 1'b1;
          else if (cu_sts.done) begin
            launched <= 1'b0;
            t1       <= cu_z;
            state    <= S_VEC2;
          end
        end
        S_VEC2: begin
          if (!launched) launched <= 1'b1;
          else if (cu_sts.done) begin
            launched <= 1'b0;
            t2       <= cu_z;
            state    <= S_ROT1;
          end
        end
        S_ROT1: begin
          if (!launched) launched <= 1'b1;
          else if (cu_sts.done) begin
            launched <= 1'b0;
            cs_c     <= cu_x[31:0];
            cs_s     <= cu_y[31:0];
            state    <= S_ROT2;
          end
        end
        S_ROT2: begin
          if (!launched) launched <= 1'b1;
          else if (cu_sts.done) begin
            launched <= 1'b0;
            hs       <= cu_y[31:0];
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          // collinear or degenerate corner: cap the magnitude
          if (hs <= 0) begin
            mag      <= MAG_CAP;
            mag_flag <= 1'b1;
            state    <= S_PMUL1;
          end else if (!launched) begin
            launched <= 1'b1;
          end else if (dv_sts.done) begin
            launched <= 1'b0;
            state    <= S_PMUL1;
            if (|dv_q[DVD_W-1:MAG_W]) begin
              mag      <= MAG_CAP;
              mag_flag <= 1'b1;
            end else begin
              mag      <= dv_q[MAG_W-1:0];
              mag_flag <= 1'b0;
            end
          end
        end
        S_PMUL1: state <= S_PMUL2;
        S_PMUL2: begin
          qx    <= PW'($signed({cx, 8'h00})) + PW'(prod_q);
          state <= S_PMUL3;
        end
        S_PMUL3: begin
          qy    <= PW'($signed({cy, 8'h00})) + PW'(prod_q);
          wi    <= '0;
          total <= '0;
          state <= S_W_RDA;
        end
        S_W_RDA: state <= S_W_RDB;
        S_W_RDB: begin
          wax   <= $signed(mem_q[31:0]);
          way   <= $signed(mem_q[63:32]);
          state <= S_W_CAPB;
        end
        S_W_CAPB: begin
          wbx   <= $signed(mem_q[31:0]);
          wby   <= $signed(mem_q[63:32]);
          state <= S_W_VA;
        end
        S_W_VA: begin
          // an edge with an end on the probe adds nothing
          if (w_skip) state <= S_W_NEXT;
          else if (!launched) launched <= 1'b1;
          else if (cu_sts.done) begin
            launched <= 1'b0;
            ang_a    <= cu_z;
            state    <= S_W_VB;
          end
        end
        S_W_VB: begin
          if (!launched) launched <= 1'b1;
          else if (cu_sts.done) begin
            launched <= 1'b0;
            total    <= total + TW'(wrap_turn(WW'(cu_z) - WW'(ang_a)));
            state    <= S_W_NEXT;
          end
        end
        S_W_NEXT: begin
          if (wi == nlast) state <= S_MMUL1;
          else begin
            wi    <= wi + 1'b1;
            state <= S_W_RDA;
          end
        end
        S_MMUL1: state <= S_MMUL2;
        S_MMUL2: begin
          mx    <= prod_q;
          state <= S_MMUL3;
        end
        S_MMUL3: begin
          my    <= prod_q;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            out_x      <= $signed(sat_x[31:0]);
            out_y      <= $signed(sat_y[31:0]);
            out_last   <= (p == nlast);
            out_status <= (mag_flag || sat_x[32] || sat_y[32]) ? ST_SAT : ST_OK;
            if (p == nlast) state <= S_IDLE;
            else begin
              p     <= p + 1'b1;
              state <= S_RD_P;
            end
          end
        end
        S_EMPTY: begin
          if (emit_load) begin
            out_x      <= '0;
            out_y      <= '0;
            out_last   <= 1'b1;
            out_status <= ST_EMPTY;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.offset_x    = out_x;
  assign out_ch.offset_y    = out_y;
  assign out_ch.last_vertex = out_last;
  assign out_ch.status      = out_status;

  `PVO_ASSERT(a_count_bound, clk, rst, 1'b1, vertex_count <= CW'(MAX_VERTICES), "count over depth")
  `PVO_ASSERT_NEXT(a_run_clears, clk, rst, in_acc && in_ch.kind == KIND_RUN, vertex_count == '0, "run left count")
  `PVO_ASSERT_NEXT(a_last_idle, clk, rst, emit_load && state == S_EMIT && p == nlast, state == S_IDLE, "no idle after last")
  `PVO_ASSERT(a_cordic_free, clk, rst, cu_ctl.start, !cu_sts.busy, "cordic started while busy")
  `PVO_ASSERT(a_div_free, clk, rst, dv_start, !dv_sts.busy, "divider started while busy")

endmodule

// File: sv/pvo_cordic.sv
// ----------------------------------------------------------------------------
// pvo_cordic
// Iterative CORDIC, one micro-rotation per cycle: vectoring or rotation.
// ----------------------------------------------------------------------------
module pvo_cordic #(
  parameter int CORDIC_STEPS = pvo_pkg::DEF_CORDIC_STEPS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pvo_pkg::cordic_ctl_t             ctl,
  input  logic signed [pvo_pkg::CDW-1:0]   x_in,
  input  logic signed [pvo_pkg::CDW-1:0]   y_in,
  input  logic signed [pvo_pkg::ZW-1:0]    z_in,
  output pvo_pkg::unit_sts_t               sts,
  output logic signed [pvo_pkg::CDW-1:0]   x_out,
  output logic signed [pvo_pkg::CDW-1:0]   y_out,
  output logic signed [pvo_pkg::ZW-1:0]    z_out
);
  import pvo_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);

  logic signed [CDW-1:0] x, y, dx, dy;
  logic signed [ZW-1:0]  z, ang;
  logic [IW-1:0]         iter;
  logic                  busy, done, rot, neg, toward_neg, last_iter;

  assign dx         = y >>> iter;
  assign dy         = x >>> iter;
  assign ang        = atan_entry(int'(iter));
  assign last_iter  = (iter == IW'(CORDIC_STEPS - 1));
  // rotation drives z to zero, vectoring drives y to zero
  assign toward_neg = rot ? (z >= 0) : (y < 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        iter <= '0;
        rot  <= ctl.rotate;
        if (ctl.rotate) begin
          x    <= GAIN_INV;
          y    <= '0;
          busy <= 1'b1;
          if (z_in > QUARTER_TURN) begin
            z   <= z_in - HALF_TURN;
            neg <= 1'b1;
          end else if (z_in < -QUARTER_TURN) begin
            z   <= z_in + HALF_TURN;
            neg <= 1'b1;
          end else begin
            z   <= z_in;
            neg <= 1'b0;
          end
        end else begin
          neg <= 1'b0;
          if (x_in == 0 && y_in == 0) begin
            x    <= '0;
            y    <= '0;
            z    <= '0;
            done <= 1'b1;
          end else if (x_in < 0) begin
            x    <= -x_in;
            y    <= -y_in;
            z    <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
            busy <= 1'b1;
          end else begin
            x    <= x_in;
            y    <= y_in;
            z    <= '0;
            busy <= 1'b1;
          end
        end
      end else if (busy) begin
        if (toward_neg) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ang;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ang;
        end
        iter <= iter + 1'b1;
        if (last_iter) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign x_out    = neg ? -x : x;
  assign y_out    = neg ? -y : y;
  assign z_out    = z;

endmodule

// File: sv/pvo_div.sv
// ----------------------------------------------------------------------------
// pvo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pvo_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pvo_pkg::DVD_W-1:0]     dividend,
  input  logic [pvo_pkg::DVS_W-1:0]     divisor,
  output pvo_pkg::unit_sts_t            sts,
  output logic [pvo_pkg::DVD_W-1:0]     quotient
);
  import pvo_pkg::*;

  localparam int NW = $clog2(DVD_W);

  logic [DVS_W-1:0] rem, dvs;
  logic [DVD_W-1:0] dvd, q;
  logic [DVS_W:0]   rem_sh;
  logic [NW-1:0]    cnt;
  logic             busy, done, fits;

  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        rem  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
        dvd <= dvd << 1;
        q   <= {q[DVD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == NW'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = q;

endmodule
